### hdl/integer_to_ascii_formatter_defines.svh
// assertion macros used by the checker file
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define I2A_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2a check failed");

// next-cycle implication, sampled on clk, quiet during rst
`define I2A_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2a check failed");

`endif

### hdl/i2a_pkg.sv
package i2a_pkg;

  localparam int VAL_W      = 64;
  localparam int DEC_DIGITS = 20;
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int HEX_DIGITS = VAL_W / 4;
  localparam int CNT_W      = 7;
  localparam int DEC_CNT_W  = 7;

  // format selector codes
  localparam logic [1:0] OP_HEX  = 2'd0;
  localparam logic [1:0] OP_DEC  = 2'd1;
  localparam logic [1:0] OP_BIN  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // character codes
  localparam logic [6:0] CH_ZERO = 7'h30;
  localparam logic [6:0] CH_X    = 7'h78;
  localparam logic [6:0] CH_B    = 7'h62;
  localparam logic [6:0] CH_USC  = 7'h5F;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] value;
    logic [7:0]       bit_count;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_item_t;

  // control from the sequencer to the decimal converter
  typedef struct packed {
    logic start;
    logic next_digit;
  } dec_ctrl_t;

  // status from the decimal converter
  typedef struct packed {
    logic       done;
    logic [3:0] digit;
  } dec_stat_t;

  localparam logic [6:0] DIGIT_CODES [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    return DIGIT_CODES[nib];
  endfunction

endpackage

### hdl/i2a_dec.sv
module i2a_dec (
  input  logic                    clk,
  input  logic                    rst,
  input  i2a_pkg::dec_ctrl_t      ctrl,
  input  logic [i2a_pkg::VAL_W-1:0] value,
  output i2a_pkg::dec_stat_t      stat
);
  import i2a_pkg::*;

  logic [VAL_W-1:0]     bin;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     adj;
  logic [DEC_CNT_W-1:0] cnt;

  // add three to every bcd digit of five or more before the doubling shift
  always_comb begin
    for (int g = 0; g < DEC_DIGITS; g++) begin
      adj[4*g +: 4] = (bcd[4*g +: 4] >= 4'd5) ? bcd[4*g +: 4] + 4'd3 : bcd[4*g +: 4];
    end
  end

  // one binary bit enters the bcd register per cycle, then digits leave msd first
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.start) begin
      bin <= value;
      bcd <= '0;
      cnt <= DEC_CNT_W'(VAL_W);
    end else if (cnt != '0) begin
      bcd <= {adj[BCD_W-2:0], bin[VAL_W-1]};
      bin <= {bin[VAL_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end else if (ctrl.next_digit) begin
      bcd <= {bcd[BCD_W-5:0], 4'h0};
    end
  end

  assign stat.done  = (cnt == '0);
  assign stat.digit = bcd[BCD_W-1 -: 4];

endmodule

### hdl/integer_to_ascii_formatter.sv
// channel | direction | handshake              | payload
// src     | in        | src_valid / src_ready  | src_data (op, value, bit_count)
// txt     | out       | txt_valid / txt_ready  | txt_data (char_code, last_char)
//
// hex: 18 characters after the accept, one per cycle while the txt channel is not stalled.
// decimal: 64 double dabble steps and a check that they are done, one skip step per
//   skipped leading zero and one more, then one character per digit.
// binary: BIN_MAX_BITS - n alignment shifts and a step to load the count, then 2 + n +
//   separators characters. rst clears the sequencer state and txt_valid; a new
// item is taken only when the sequencer is idle, and a stalled txt channel holds it.
module integer_to_ascii_formatter #(
  parameter int BIN_MAX_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  i2a_pkg::in_item_t  src_data,
  output logic               txt_valid,
  input  logic               txt_ready,
  output i2a_pkg::out_item_t txt_data
);
  import i2a_pkg::*;

  localparam int BIN_SHIFT = VAL_W - BIN_MAX_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_ALIGN, S_PFX0, S_PFX1, S_HEX, S_DCONV, S_DSKIP, S_DOUT, S_BIN, S_USC
  } state_t;

  state_t           state;
  logic [1:0]       op;
  logic [VAL_W-1:0] sreg;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] nbits;
  logic [CNT_W-1:0] nb_sat;
  logic             emit;
  logic             take;
  logic             char_load;
  dec_ctrl_t        dctrl;
  dec_stat_t        dstat;

  assign src_ready = (state == S_IDLE);
  assign take      = src_valid && src_ready;
  assign emit      = !txt_valid || txt_ready;

  // a character enters the output register this cycle
  assign char_load = emit && (state inside {S_PFX0, S_PFX1, S_HEX, S_DOUT, S_BIN, S_USC});

  // binary digit count saturates at the parameter
  assign nb_sat = (src_data.bit_count > 8'(BIN_MAX_BITS)) ? CNT_W'(BIN_MAX_BITS)
                                                          : CNT_W'(src_data.bit_count);

  // decimal converter control
  always_comb begin
    dctrl.start      = take && (src_data.op == OP_DEC);
    dctrl.next_digit = ((state == S_DSKIP) && (dstat.digit == 4'h0) && (cnt > CNT_W'(1))) ||
                       ((state == S_DOUT) && emit);
  end

  i2a_dec u_dec (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (dctrl),
    .value (src_data.value),
    .stat  (dstat)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      txt_valid <= 1'b0;
    end else begin
      if (txt_valid && txt_ready && !char_load) begin
        txt_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            op <= src_data.op;
            case (src_data.op)
              OP_HEX: begin
                sreg  <= src_data.value;
                cnt   <= CNT_W'(HEX_DIGITS);
                state <= S_PFX0;
              end
              OP_DEC: begin
                state <= S_DCONV;
              end
              OP_BIN: begin
                sreg  <= src_data.value << BIN_SHIFT;
                nbits <= nb_sat;
                cnt   <= CNT_W'(BIN_MAX_BITS) - nb_sat;
                state <= S_ALIGN;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // drop unused high bits so the first printed bit sits at the top
        S_ALIGN: begin
          if (cnt != '0) begin
            sreg <= {sreg[VAL_W-2:0], 1'b0};
            cnt  <= cnt - 1'b1;
          end else begin
            cnt   <= nbits;
            state <= S_PFX0;
          end
        end
        S_PFX0: begin
          if (emit) begin
            txt_valid <= 1'b1;
            txt_data  <= '{char_code: CH_ZERO, last_char: 1'b0};
            state     <= S_PFX1;
          end
        end
        S_PFX1: begin
          if (emit) begin
            txt_valid <= 1'b1;
            if (op == OP_HEX) begin
              txt_data <= '{char_code: CH_X, last_char: 1'b0};
              state    <= S_HEX;
            end else begin
              txt_data <= '{char_code: CH_B, last_char: (cnt == '0)};
              state    <= (cnt == '0) ? S_IDLE : S_BIN;
            end
          end
        end
        S_HEX: begin
          if (emit) begin
            txt_valid <= 1'b1;
            txt_data  <= '{char_code: hex_char(sreg[VAL_W-1 -: 4]),
                           last_char: (cnt == CNT_W'(1))};
            sreg      <= {sreg[VAL_W-5:0], 4'h0};
            cnt       <= cnt - 1'b1;
            if (cnt == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_DCONV: begin
          if (dstat.done) begin
            cnt   <= CNT_W'(DEC_DIGITS);
            state <= S_DSKIP;
          end
        end
        // skip leading zeros, keeping at least one digit
        S_DSKIP: begin
          if ((dstat.digit == 4'h0) && (cnt > CNT_W'(1))) begin
            cnt <= cnt - 1'b1;
          end else begin
            state <= S_DOUT;
          end
        end
        S_DOUT: begin
          if (emit) begin
            txt_valid <= 1'b1;
            txt_data  <= '{char_code: CH_ZERO + 7'(dstat.digit),
                           last_char: (cnt == CNT_W'(1))};
            cnt       <= cnt - 1'b1;
            if (cnt == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        // cnt holds the bits still to print; the current bit sits at position cnt-1
        S_BIN: begin
          if (emit) begin
            txt_valid <= 1'b1;
            txt_data  <= '{char_code: CH_ZERO + 7'(sreg[VAL_W-1]),
                           last_char: (cnt == CNT_W'(1))};
            sreg      <= {sreg[VAL_W-2:0], 1'b0};
            cnt       <= cnt - 1'b1;
            if (cnt == CNT_W'(1)) begin
              state <= S_IDLE;
            end else if (cnt[1:0] == 2'b01) begin
              state <= S_USC;
            end
          end
        end
        S_USC: begin
          if (emit) begin
            txt_valid <= 1'b1;
            txt_data  <= '{char_code: CH_USC, last_char: 1'b0};
            state     <= S_BIN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/i2a_chk.sv
`include "integer_to_ascii_formatter_defines.svh"

module i2a_chk (
  input logic               clk,
  input logic               rst,
  input logic               src_valid,
  input logic               src_ready,
  input i2a_pkg::in_item_t  src_data,
  input logic               txt_valid,
  input logic               txt_ready,
  input i2a_pkg::out_item_t txt_data
);
  import i2a_pkg::*;

  // a stalled character holds
  `I2A_ASSERT_NEXT(a_txt_hold, txt_valid && !txt_ready, txt_valid && $stable(txt_data))

  // no new transaction is taken while text of the current one is still pending
  `I2A_ASSERT_IMP(a_busy_mid_text, txt_valid && !txt_data.last_char, !src_ready)

  // a transaction with a meaningless selector produces nothing and leaves the block idle
  `I2A_ASSERT_NEXT(a_none_idle, src_valid && src_ready && (src_data.op == OP_NONE), src_ready)

  // a valid format keeps the block busy for at least the next cycle
  `I2A_ASSERT_NEXT(a_fmt_busy, src_valid && src_ready && (src_data.op != OP_NONE), !src_ready)

  // text never ends on a prefix letter x or a separator
  `I2A_ASSERT_IMP(a_last_char_ok, txt_valid && txt_data.last_char,
                  (txt_data.char_code != CH_X) && (txt_data.char_code != CH_USC))

endmodule

bind integer_to_ascii_formatter i2a_chk u_i2a_chk (.*);
